[rtl/three_level_priority_fifo_top_macros.svh]
// Assertion macros shared by the three-level priority FIFO RTL.
`ifndef THREE_LEVEL_PRIORITY_FIFO_TOP_MACROS_SVH
`define THREE_LEVEL_PRIORITY_FIFO_TOP_MACROS_SVH

// Checks that a condition implies another one at the same clock edge.
`define TLPF_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Checks that a condition implies another one at the following clock edge.
`define TLPF_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

// Checks that a condition always holds outside reset.
`define TLPF_ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error("assertion failed: invariant");

`endif

[rtl/tlpf_pkg.sv]
// Types and codes shared by the three-level priority FIFO modules.
package tlpf_pkg;

    // Number of priority rings and the width of a ring index.
    localparam int NUM_RINGS = 3;
    localparam int RING_W    = 2;

    // Operation codes of an input transaction.
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_SERVICE = 1'b1;

    // Priority class codes.
    localparam logic [1:0] CLASS_NONE      = 2'd0;
    localparam logic [1:0] CLASS_URGENT    = 2'd1;
    localparam logic [1:0] CLASS_IMPORTANT = 2'd2;
    localparam logic [1:0] CLASS_STANDARD  = 2'd3;

    // Result status codes.
    localparam logic [2:0] ST_ACCEPTED  = 3'd0;
    localparam logic [2:0] ST_BAD_PRIO  = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_SERVED    = 3'd3;
    localparam logic [2:0] ST_ALL_EMPTY = 3'd4;

    // One input transaction.
    typedef struct packed {
        logic        op;
        logic [1:0]  priority_class;
        logic [31:0] payload;
        logic [6:0]  age;
    } tlpf_in_t;

    // One result transaction.
    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  served_class;
        logic [31:0] out_payload;
        logic [6:0]  out_age;
        logic        last;
    } tlpf_out_t;

    // One stored queue entry.
    typedef struct packed {
        logic [31:0] payload;
        logic [6:0]  age;
    } tlpf_entry_t;

endpackage

[rtl/tlpf_entry_ram.sv]
// Entry memory for all three rings: one write port, one registered read port.
module tlpf_entry_ram #(
    parameter int DEPTH  = 48,
    parameter int ADDR_W = 6
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  tlpf_pkg::tlpf_entry_t wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    rd_addr,
    output tlpf_pkg::tlpf_entry_t rd_data
);

    tlpf_pkg::tlpf_entry_t mem [DEPTH];
    tlpf_pkg::tlpf_entry_t rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data register holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/three_level_priority_fifo_top.sv]
// Top level of the three-level priority FIFO: ring control and result register.
// The block holds three rings (urgent, important, standard) of QUEUE_DEPTH entries
// each in one shared memory of 3*QUEUE_DEPTH entries; stored entries are undefined
// until written, and no clearing pass runs after reset. An enqueue transaction
// yields one status result. A service transaction that finds k non-empty rings
// yields k results, one per ring head, in urgent, important, standard order with
// the last one marked; with all rings empty it yields a single all-empty result.
// The service time is set by the single read port of the entry memory, which
// delivers one ring head per cycle while the output register is free or being
// taken. One transaction is worked on at a time, and a finished result in the
// output register does not stop the next transaction from being accepted when
// the result is taken in the same cycle.
`include "three_level_priority_fifo_top_macros.svh"

module three_level_priority_fifo_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tlpf_pkg::tlpf_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tlpf_pkg::tlpf_out_t m_data
);

    localparam int MEM_DEPTH = tlpf_pkg::NUM_RINGS * QUEUE_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int RW        = tlpf_pkg::RING_W;
    localparam int NR        = tlpf_pkg::NUM_RINGS;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    state_t              state_reg;
    logic                m_valid_reg;
    tlpf_pkg::tlpf_out_t m_data_reg;
    logic [PTR_W-1:0]    head_reg  [NR];
    logic [PTR_W-1:0]    tail_reg  [NR];
    logic [CNT_W-1:0]    count_reg [NR];
    logic [NR-1:0]       mask_reg;
    logic [RW-1:0]       cur_ring_reg;

    logic                  out_free;
    logic                  in_acc;
    logic                  out_load;
    logic [NR-1:0]         nonempty;
    logic [NR-1:0]         scan_mask;
    logic [NR-1:0]         mask_next;
    logic [RW-1:0]         sel_ring;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic [RW-1:0]         enq_ring;
    logic                  enq_class_ok;
    logic                  enq_full;
    logic [2:0]            enq_status;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    tlpf_pkg::tlpf_entry_t wr_data;
    tlpf_pkg::tlpf_entry_t rd_data;

    // Handshake: one transaction at a time, output register must be free or leaving.
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign in_acc   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // A result is loaded for every accepted transaction except the start of a
    // round on non-empty rings, and for each ring head during a round.
    assign out_load = (in_acc && !((s_data.op == tlpf_pkg::OP_SERVICE) && (|nonempty)))
                   || ((state_reg == ST_EMIT) && out_free);

    // Pick the highest-priority ring still to be served in this round.
    always_comb begin
        for (int i = 0; i < NR; i++) begin
            nonempty[i] = (count_reg[i] != '0);
        end
        scan_mask = (state_reg == ST_IDLE) ? nonempty : mask_reg;
        if (scan_mask[0]) begin
            sel_ring = RW'(0);
        end else if (scan_mask[1]) begin
            sel_ring = RW'(1);
        end else begin
            sel_ring = RW'(2);
        end
        for (int i = 0; i < NR; i++) begin
            mask_next[i] = scan_mask[i] && (sel_ring != RW'(i));
        end
    end

    // Head read: at the start of a round, and after each result while rings remain.
    assign rd_en = (in_acc && (s_data.op == tlpf_pkg::OP_SERVICE) && (|nonempty))
                || ((state_reg == ST_EMIT) && out_free && (|mask_reg));
    assign rd_addr = ADDR_W'(sel_ring) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_reg[sel_ring]);

    // Decode the class of an enqueue into a ring and check its fill level.
    always_comb begin
        enq_class_ok = 1'b1;
        case (s_data.priority_class)
            tlpf_pkg::CLASS_URGENT:    enq_ring = RW'(0);
            tlpf_pkg::CLASS_IMPORTANT: enq_ring = RW'(1);
            tlpf_pkg::CLASS_STANDARD:  enq_ring = RW'(2);
            default: begin
                enq_ring     = RW'(0);
                enq_class_ok = 1'b0;
            end
        endcase
        enq_full = (count_reg[enq_ring] == CNT_W'(QUEUE_DEPTH));
        if (!enq_class_ok) begin
            enq_status = tlpf_pkg::ST_BAD_PRIO;
        end else if (enq_full) begin
            enq_status = tlpf_pkg::ST_FULL;
        end else begin
            enq_status = tlpf_pkg::ST_ACCEPTED;
        end
    end

    // Tail write of an accepted enqueue.
    assign wr_en = in_acc && (s_data.op == tlpf_pkg::OP_ENQUEUE) && enq_class_ok && !enq_full;
    assign wr_addr = ADDR_W'(enq_ring) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail_reg[enq_ring]);
    assign wr_data = '{payload: s_data.payload, age: s_data.age};

    tlpf_entry_ram #(
        .DEPTH  (MEM_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Controller state, ring pointers and the result register. Enqueue writes and
    // head reads never share a cycle, so no forwarding is needed on the memory.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            mask_reg     <= '0;
            cur_ring_reg <= '0;
            for (int i = 0; i < NR; i++) begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end else begin
            // Result valid: set when a result is loaded, cleared when it is taken.
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // Advance the head of the ring being read.
            if (rd_en) begin
                head_reg[sel_ring]  <= (head_reg[sel_ring] == PTR_W'(QUEUE_DEPTH - 1))
                                     ? '0 : head_reg[sel_ring] + PTR_W'(1);
                count_reg[sel_ring] <= count_reg[sel_ring] - CNT_W'(1);
                mask_reg            <= mask_next;
                cur_ring_reg        <= sel_ring;
            end

            // Advance the tail of the ring being written.
            if (wr_en) begin
                tail_reg[enq_ring]  <= (tail_reg[enq_ring] == PTR_W'(QUEUE_DEPTH - 1))
                                     ? '0 : tail_reg[enq_ring] + PTR_W'(1);
                count_reg[enq_ring] <= count_reg[enq_ring] + CNT_W'(1);
            end

            case (state_reg)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (s_data.op == tlpf_pkg::OP_ENQUEUE) begin
                            m_data_reg  <= '{status: enq_status,
                                             served_class: tlpf_pkg::CLASS_NONE,
                                             out_payload: '0, out_age: '0, last: 1'b1};
                        end else if (|nonempty) begin
                            state_reg <= ST_EMIT;
                        end else begin
                            m_data_reg  <= '{status: tlpf_pkg::ST_ALL_EMPTY,
                                             served_class: tlpf_pkg::CLASS_NONE,
                                             out_payload: '0, out_age: '0, last: 1'b1};
                        end
                    end
                end
                ST_EMIT: begin
                    // Read data of the ring in cur_ring_reg is valid here.
                    if (out_free) begin
                        m_data_reg  <= '{status: tlpf_pkg::ST_SERVED,
                                         served_class: 2'(cur_ring_reg + RW'(1)),
                                         out_payload: rd_data.payload,
                                         out_age: rd_data.age,
                                         last: (mask_reg == '0)};
                        if (mask_reg == '0) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // A head is read only from a ring that holds entries.
    `TLPF_ASSERT_IMP(a_read_nonempty, aclk, aresetn, rd_en, count_reg[sel_ring] != '0)
    // No new transaction is taken while a round still has results to come.
    `TLPF_ASSERT_IMP(a_round_blocks_input, aclk, aresetn, m_valid && !m_data.last, !s_ready)
    // A served result always names a ring class.
    `TLPF_ASSERT_IMP(a_served_class, aclk, aresetn,
                     m_valid && (m_data.status == tlpf_pkg::ST_SERVED),
                     m_data.served_class != tlpf_pkg::CLASS_NONE)
    // Fill counts never pass the ring depth.
    `TLPF_ASSERT_ALWAYS(a_fill_bound, aclk, aresetn,
                        (count_reg[0] <= CNT_W'(QUEUE_DEPTH)) &&
                        (count_reg[1] <= CNT_W'(QUEUE_DEPTH)) &&
                        (count_reg[2] <= CNT_W'(QUEUE_DEPTH)))
    // Starting a service round on non-empty rings moves the controller to emit.
    `TLPF_ASSERT_NXT(a_round_start, aclk, aresetn,
                     in_acc && (s_data.op == tlpf_pkg::OP_SERVICE) && (|nonempty),
                     state_reg == ST_EMIT)

endmodule
